### hdl/mtlwc_pkg.sv
// ----------------------------------------------------------------------------
// mtlwc_pkg
// Shared types, character codes and helpers for the memh text loader with
// write combining.
// ----------------------------------------------------------------------------
`default_nettype none

package mtlwc_pkg;

  // Default line buffer length; only the first LINE_CHARS-1 characters count.
  localparam int LINE_CHARS_DEF = 256;

  // Character codes that steer the parser.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_N     = 8'h4E;

  // Result kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Progress of the parser through one line.
  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_ECAND     = 3'd1,
    PH_ADDR      = 3'd2,
    PH_ADDR_DONE = 3'd3,
    PH_DATA      = 3'd4,
    PH_SKIP      = 3'd5,
    PH_END_DONE  = 3'd6
  } phase_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [63:0] word_address;
    logic [63:0] word_value;
    logic [7:0]  byte_strobe;
    logic [31:0] bytes_loaded;
    logic [31:0] writes_issued;
    logic        last;
  } result_t;

  // Decoded hex digit: valid flag and value.
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } digit_t;

  function automatic digit_t hex_digit(input logic [7:0] c);
    digit_t d;
    d.valid = 1'b1;
    d.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      d.value = c[3:0] + 4'd9;
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic result_t write_result(input logic [63:0] base,
                                           input logic [63:0] data,
                                           input logic [7:0]  strobe);
    result_t r;
    r = '0;
    r.kind         = KIND_WRITE;
    r.word_address = base;
    r.word_value   = data;
    r.byte_strobe  = strobe;
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/memh_text_loader_write_combiner_core.sv
// Each result item is registered in the result queue when its character is accepted.
// Throughput: one character per cycle while the queue has room; a character that yields
// two items sends them out one at a time, and the four-entry result queue sets how far input runs ahead.
// Reset (synchronous, active high): parse state, address, word and counters cleared,
// result queue emptied; no clearing pass.
// ----------------------------------------------------------------------------
// memh_text_loader_write_combiner_core
// Parses memh text one character at a time and emits combined 64-bit writes
// and a done item with byte and write totals.
// ----------------------------------------------------------------------------
`default_nettype none

module memh_text_loader_write_combiner_core #(
  parameter int LINE_CHARS = mtlwc_pkg::LINE_CHARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [63:0]      word_address,
  output logic [63:0]      word_value,
  output logic [7:0]       byte_strobe,
  output logic [31:0]      bytes_loaded,
  output logic [31:0]      writes_issued,
  output logic             last
);
  import mtlwc_pkg::*;

  result_t    res0;
  result_t    res1;
  result_t    head;
  logic [1:0] res_count;
  logic       room;
  logic       take;

  // A character is taken whenever the queue can hold two more items.
  assign in_ready = room;
  assign take     = in_valid && room;

  mtlwc_parse #(
    .LINE_CHARS(LINE_CHARS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (char_code),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  mtlwc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push0      (res0),
    .push1      (res1),
    .push_count (res_count),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .head       (head)
  );

  // Output fields.
  assign kind          = head.kind;
  assign word_address  = head.word_address;
  assign word_value    = head.word_value;
  assign byte_strobe   = head.byte_strobe;
  assign bytes_loaded  = head.bytes_loaded;
  assign writes_issued = head.writes_issued;
  assign last          = head.last;

endmodule

`default_nettype wire

### hdl/mtlwc_parse.sv
// ----------------------------------------------------------------------------
// mtlwc_parse
// Line parser and write combiner. Holds the whole parse state and turns one
// character into zero, one or two result items combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module mtlwc_parse #(
  parameter int LINE_CHARS = mtlwc_pkg::LINE_CHARS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        char_code,
  output mtlwc_pkg::result_t     res0,
  output mtlwc_pkg::result_t     res1,
  output logic [1:0]             res_count
);
  import mtlwc_pkg::*;

  localparam int CW = $clog2(LINE_CHARS);

  // Parse state registers.
  logic [CW-1:0] line_column,  line_column_next;
  phase_t        line_phase,   line_phase_next;
  logic [1:0]    end_match,    end_match_next;
  logic          held_valid,   held_valid_next;
  logic [3:0]    held_value,   held_value_next;
  logic [63:0]   running_address, running_address_next;
  logic [63:0]   address_accum,   address_accum_next;
  logic          address_digit_seen, address_digit_seen_next;
  logic [63:0]   word_base,    word_base_next;
  logic [63:0]   word_data,    word_data_next;
  logic [7:0]    word_strobe,  word_strobe_next;
  logic [31:0]   byte_counter, byte_counter_next;
  logic [31:0]   write_counter, write_counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_column        <= '0;
      line_phase         <= PH_START;
      end_match          <= '0;
      held_valid         <= 1'b0;
      held_value         <= '0;
      running_address    <= '0;
      address_accum      <= '0;
      address_digit_seen <= 1'b0;
      word_base          <= '0;
      word_data          <= '0;
      word_strobe        <= '0;
      byte_counter       <= '0;
      write_counter      <= '0;
    end else begin
      line_column        <= line_column_next;
      line_phase         <= line_phase_next;
      end_match          <= end_match_next;
      held_valid         <= held_valid_next;
      held_value         <= held_value_next;
      running_address    <= running_address_next;
      address_accum      <= address_accum_next;
      address_digit_seen <= address_digit_seen_next;
      word_base          <= word_base_next;
      word_data          <= word_data_next;
      word_strobe        <= word_strobe_next;
      byte_counter       <= byte_counter_next;
      write_counter      <= write_counter_next;
    end
  end

  // Next state and results. The character first sets a few action flags,
  // then the flush, merge and done actions run in that order.
  always_comb begin
    digit_t      d;
    logic        do_flush;
    logic        do_merge;
    logic        do_done;
    logic [7:0]  merge_val;
    logic [63:0] nb;
    logic [2:0]  lane;
    logic [1:0]  n;
    result_t     done_res;

    d         = hex_digit(char_code);
    do_flush  = 1'b0;
    do_merge  = 1'b0;
    do_done   = 1'b0;
    merge_val = {held_value, d.value};
    nb        = {running_address[63:3], 3'b000};
    lane      = running_address[2:0];
    n         = 2'd0;
    done_res  = '0;
    res0      = '0;
    res1      = '0;

    line_column_next        = line_column;
    line_phase_next         = line_phase;
    end_match_next          = end_match;
    held_valid_next         = held_valid;
    held_value_next         = held_value;
    running_address_next    = running_address;
    address_accum_next      = address_accum;
    address_digit_seen_next = address_digit_seen;
    word_base_next          = word_base;
    word_data_next          = word_data;
    word_strobe_next        = word_strobe;
    byte_counter_next       = byte_counter;
    write_counter_next      = write_counter;

    // Decode the character against the line phase.
    if (take && char_code != CH_CR) begin
      if (char_code == CH_LF) begin
        if (line_phase == PH_ADDR || line_phase == PH_ADDR_DONE) begin
          if (address_digit_seen) begin
            running_address_next = address_accum;
          end
        end else if (line_phase == PH_END_DONE ||
                     (line_phase == PH_ECAND && end_match == 2'd3)) begin
          do_flush = 1'b1;
          do_done  = 1'b1;
        end
        line_column_next = '0;
        line_phase_next  = PH_START;
        end_match_next   = '0;
        held_valid_next  = 1'b0;
        held_value_next  = '0;
      end else if (line_column < CW'(LINE_CHARS - 1)) begin
        line_column_next = line_column + CW'(1);
        case (line_phase)
          PH_START: begin
            if (!is_blank(char_code)) begin
              if (char_code == CH_AT) begin
                do_flush                = 1'b1;
                address_accum_next      = '0;
                address_digit_seen_next = 1'b0;
                line_phase_next         = PH_ADDR;
              end else if (char_code == CH_E) begin
                held_valid_next = 1'b1;
                held_value_next = 4'hE;
                end_match_next  = 2'd1;
                line_phase_next = PH_ECAND;
              end else if (d.valid) begin
                held_valid_next = 1'b1;
                held_value_next = d.value;
                line_phase_next = PH_DATA;
              end else begin
                line_phase_next = PH_SKIP;
              end
            end
          end
          PH_ECAND: begin
            if (end_match == 2'd1) begin
              held_valid_next = 1'b0;
              held_value_next = '0;
              if (char_code == CH_N) begin
                end_match_next = 2'd2;
              end else if (d.valid) begin
                do_merge        = 1'b1;
                end_match_next  = '0;
                line_phase_next = PH_DATA;
              end else begin
                line_phase_next = PH_SKIP;
              end
            end else if (end_match == 2'd2) begin
              if (char_code == CH_D) begin
                end_match_next = 2'd3;
              end else begin
                line_phase_next = PH_SKIP;
              end
            end else begin
              if (is_blank(char_code) || char_code == CH_NUL) begin
                line_phase_next = PH_END_DONE;
              end else begin
                line_phase_next = PH_SKIP;
              end
            end
          end
          PH_ADDR: begin
            if (d.valid) begin
              address_accum_next      = {address_accum[59:0], d.value};
              address_digit_seen_next = 1'b1;
            end else begin
              line_phase_next = PH_ADDR_DONE;
            end
          end
          PH_DATA: begin
            if (!held_valid) begin
              if (!is_blank(char_code)) begin
                if (d.valid) begin
                  held_valid_next = 1'b1;
                  held_value_next = d.value;
                end else begin
                  line_phase_next = PH_SKIP;
                end
              end
            end else begin
              if (d.valid) begin
                do_merge = 1'b1;
              end else begin
                line_phase_next = PH_SKIP;
              end
              held_valid_next = 1'b0;
              held_value_next = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // Flush of the pending word before an address line or a done.
    if (do_flush && word_strobe_next != 8'd0) begin
      res0               = write_result(word_base_next, word_data_next, word_strobe_next);
      n                  = 2'd1;
      word_data_next     = '0;
      word_strobe_next   = '0;
      write_counter_next = write_counter_next + 32'd1;
    end

    // Merge one byte into the aligned word, flushing on a base change or when full.
    if (do_merge) begin
      if (word_strobe_next == 8'd0) begin
        word_base_next = nb;
      end else if (word_base_next != nb) begin
        res0               = write_result(word_base_next, word_data_next, word_strobe_next);
        n                  = 2'd1;
        word_data_next     = '0;
        word_strobe_next   = '0;
        write_counter_next = write_counter_next + 32'd1;
        word_base_next     = nb;
      end
      word_data_next   = word_data_next | ({56'd0, merge_val} << {lane, 3'b000});
      word_strobe_next = word_strobe_next | (8'd1 << lane);
      if (word_strobe_next == 8'hFF) begin
        if (n == 2'd0) begin
          res0 = write_result(word_base_next, word_data_next, word_strobe_next);
        end else begin
          res1 = write_result(word_base_next, word_data_next, word_strobe_next);
        end
        n                  = n + 2'd1;
        word_data_next     = '0;
        word_strobe_next   = '0;
        write_counter_next = write_counter_next + 32'd1;
      end
      running_address_next = running_address + 64'd1;
      byte_counter_next    = byte_counter + 32'd1;
    end

    // Done item, then everything returns to its reset value.
    if (do_done) begin
      done_res.kind          = KIND_DONE;
      done_res.bytes_loaded  = byte_counter_next;
      done_res.writes_issued = write_counter_next;
      if (n == 2'd0) begin
        res0 = done_res;
      end else begin
        res1 = done_res;
      end
      n = n + 2'd1;
      line_column_next        = '0;
      line_phase_next         = PH_START;
      end_match_next          = '0;
      held_valid_next         = 1'b0;
      held_value_next         = '0;
      running_address_next    = '0;
      address_accum_next      = '0;
      address_digit_seen_next = 1'b0;
      word_base_next          = '0;
      word_data_next          = '0;
      word_strobe_next        = '0;
      byte_counter_next       = '0;
      write_counter_next      = '0;
    end

    // Mark the final item caused by this character.
    if (n == 2'd2) begin
      res1.last = 1'b1;
    end else if (n == 2'd1) begin
      res0.last = 1'b1;
    end
    res_count = n;
  end

endmodule

`default_nettype wire

### hdl/mtlwc_queue.sv
// ----------------------------------------------------------------------------
// mtlwc_queue
// Four-entry result queue. Takes up to two items per cycle from the parser
// and presents one registered item per cycle on the output channel while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mtlwc_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mtlwc_pkg::result_t push0,
  input  wire mtlwc_pkg::result_t push1,
  input  wire logic [1:0]         push_count,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mtlwc_pkg::result_t      head
);
  import mtlwc_pkg::*;

  // Item storage and pointers.
  result_t    entries [4];
  logic [1:0] wr_ptr, wr_ptr_next;
  logic [1:0] rd_ptr, rd_ptr_next;
  logic [2:0] count,  count_next;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 3'd0;
  assign head      = entries[rd_ptr];
  // Room for the worst case of two items from one character.
  assign room      = count <= 3'd2;

  always_comb begin
    wr_ptr_next = wr_ptr + push_count;
    rd_ptr_next = rd_ptr + {1'b0, pop};
    count_next  = count + {1'b0, push_count} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Item writes need no reset.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push1;
    end
  end

endmodule

`default_nettype wire
